// File: sv/ultrasonic_echo_ranger_core_assert.svh
// Assertion macros used by the ranger top level.
`ifndef ULTRASONIC_ECHO_RANGER_CORE_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UER_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ranger assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UER_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ranger assertion failed");

`endif

// File: sv/uer_pkg.sv
package uer_pkg;

    // Measurement ring buffer.
    localparam int FIFO_DEPTH  = 128;
    localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
    localparam int COUNT_BITS  = 24;
    localparam int WIDTH_BITS  = 24;
    localparam int ENTRY_BITS  = WIDTH_BITS + 1;

    // Configuration registers.
    localparam int TRIG_BITS     = 16;
    localparam int TIMEOUT_BITS  = 24;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;
    localparam logic [TRIG_BITS-1:0]    TRIG_RESET    = 16'd20;
    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 24'd50000;

    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_TRIG_PULSE = 2'd0;
    localparam cfg_idx_t REG_TIMEOUT    = 2'd1;

    // Result queue between the tick engine and the output port.
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    // What the tick engine knows about a tick before the buffer data returns.
    typedef struct packed {
        logic trig_level;
        logic data_ready;
        logic pop;
        logic empty;
    } desc_t;

    typedef struct packed {
        logic                  trig_level;
        logic                  data_ready;
        logic                  read_ok;
        logic                  read_timeout;
        logic                  read_empty;
        logic [WIDTH_BITS-1:0] read_width;
    } result_t;

    typedef struct packed {
        logic                  we;
        logic [PTR_BITS-1:0]   waddr;
        logic [ENTRY_BITS-1:0] wdata;
        logic                  re;
        logic [PTR_BITS-1:0]   raddr;
    } ram_req_t;

    function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
        logic [PTR_BITS-1:0] n;
        if (p == PTR_BITS'(FIFO_DEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + 1'b1;
        end
        return n;
    endfunction

    // Clamp the running count to the width field of an entry.
    function automatic logic [WIDTH_BITS-1:0] sat_width(input logic [COUNT_BITS-1:0] c);
        logic [WIDTH_BITS-1:0] w;
        if (64'(c) > ((64'd1 << WIDTH_BITS) - 64'd1)) begin
            w = '1;
        end else begin
            w = WIDTH_BITS'(c);
        end
        return w;
    endfunction

endpackage

// File: sv/ultrasonic_echo_ranger_core.sv
// Ultrasonic echo ranger: one input beat is one timing tick, one output beat per tick.
// Throughput: one beat per cycle while the result queue has room; tick state is
// updated combinationally. The buffer read and tick summary are registered, then queued.
// Reset: synchronous, active low; clears pointers, counters and the result queue and
// loads the configuration defaults. The measurement buffer RAM is not cleared.
`include "ultrasonic_echo_ranger_core_assert.svh"

module ultrasonic_echo_ranger_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [uer_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [uer_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // Tick input channel.
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_echo_level,
    input  logic                               s_trigger,
    input  logic                               s_read_req,
    // Result channel.
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_trig_level,
    output logic                               m_data_ready,
    output logic                               m_read_ok,
    output logic                               m_read_timeout,
    output logic                               m_read_empty,
    output logic [uer_pkg::WIDTH_BITS-1:0]     m_read_width
);

    // The front end runs the trigger, echo and timeout logic for each accepted
    // beat and owns the ring pointers. It issues one write and one read to the
    // buffer RAM per tick. A pop reads the entry at the read pointer; since a
    // valid pop only targets a slot written on an earlier tick, no bypass is
    // needed. The summary of the tick is registered so that it lines up with
    // the RAM read data.
    //
    // The back end merges summary and read data into a result and writes it
    // into a short queue that drives the output port. The front end only takes
    // a beat when the queue has room for it and for the tick still in flight,
    // so the two sides stall independently and a stalled output does not lose
    // results.

    logic                           desc_valid;
    uer_pkg::desc_t                 desc;
    uer_pkg::ram_req_t              ram_req;
    logic [uer_pkg::ENTRY_BITS-1:0] ram_rdata;
    logic [uer_pkg::QCNT_BITS-1:0]  back_count;

    uer_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_echo_level(s_echo_level),
        .s_trigger   (s_trigger),
        .s_read_req  (s_read_req),
        .back_count  (back_count),
        .desc_valid  (desc_valid),
        .desc        (desc),
        .ram_req     (ram_req)
    );

    // Measurement buffer: bit 24 marks a timeout, bits 23..0 hold a width.
    uer_ram #(
        .WIDTH(uer_pkg::ENTRY_BITS),
        .DEPTH(uer_pkg::FIFO_DEPTH)
    ) u_store (
        .clk  (aclk),
        .we   (ram_req.we),
        .waddr(ram_req.waddr),
        .wdata(ram_req.wdata),
        .re   (ram_req.re),
        .raddr(ram_req.raddr),
        .rdata(ram_rdata)
    );

    uer_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .desc_valid    (desc_valid),
        .desc          (desc),
        .rdata         (ram_rdata),
        .back_count    (back_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_trig_level  (m_trig_level),
        .m_data_ready  (m_data_ready),
        .m_read_ok     (m_read_ok),
        .m_read_timeout(m_read_timeout),
        .m_read_empty  (m_read_empty),
        .m_read_width  (m_read_width)
    );

    // The queue plus the tick in flight never exceed the queue depth.
    `UER_ASSERT_NOW(a_queue_room, aclk, aresetn, 1'b1, (32'(back_count) + 32'(desc_valid)) <= uer_pkg::QDEPTH)
    // Every accepted beat reaches the back end on the next cycle.
    `UER_ASSERT_NEXT(a_tick_in_flight, aclk, aresetn, s_valid && s_ready, desc_valid)
    // A result reports at most one read outcome.
    `UER_ASSERT_NOW(a_read_onehot, aclk, aresetn, m_valid, $onehot0({m_read_ok, m_read_timeout, m_read_empty}))
    // The width is zero unless the read returned a measurement.
    `UER_ASSERT_NOW(a_width_zero, aclk, aresetn, m_valid && !m_read_ok, m_read_width == '0)

endmodule

// File: sv/uer_ram.sv
module uer_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/uer_front.sv
module uer_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [uer_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [uer_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_echo_level,
    input  logic                               s_trigger,
    input  logic                               s_read_req,
    input  logic [uer_pkg::QCNT_BITS-1:0]      back_count,
    output logic                               desc_valid,
    output uer_pkg::desc_t                     desc,
    output uer_pkg::ram_req_t                  ram_req
);

    logic [uer_pkg::TRIG_BITS-1:0]    trig_pulse_reg;
    logic [uer_pkg::TIMEOUT_BITS-1:0] timeout_reg;

    logic                             echo_prev_reg, echo_prev_next;
    logic                             rise_seen_reg, rise_seen_next;
    logic [uer_pkg::COUNT_BITS-1:0]   width_count_reg, width_count_next;
    logic [uer_pkg::TRIG_BITS-1:0]    trig_count_reg, trig_count_next;
    logic [uer_pkg::TIMEOUT_BITS-1:0] timeout_count_reg, timeout_count_next;
    logic                             timer_running_reg, timer_running_next;
    logic [uer_pkg::PTR_BITS-1:0]     read_ptr_reg, read_ptr_next;
    logic [uer_pkg::PTR_BITS-1:0]     write_ptr_reg, write_ptr_next;
    logic                             desc_valid_reg;
    uer_pkg::desc_t                   desc_reg, desc_next;

    logic                             accept;
    logic                             pop, empty, trig_out, push, push_ok;
    logic [uer_pkg::ENTRY_BITS-1:0]   entry;
    logic [uer_pkg::PTR_BITS-1:0]     write_ptr_inc;
    logic [uer_pkg::QCNT_BITS:0]      occupancy;

    // Room is counted for the queue plus the tick whose data is in flight.
    assign occupancy = {1'b0, back_count} + {{uer_pkg::QCNT_BITS{1'b0}}, desc_valid_reg};
    assign s_ready   = occupancy < (uer_pkg::QCNT_BITS + 1)'(uer_pkg::QDEPTH);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        // Read sees the buffer as it stood at the start of the tick.
        pop           = s_read_req && (read_ptr_reg != write_ptr_reg);
        empty         = s_read_req && (read_ptr_reg == write_ptr_reg);
        read_ptr_next = pop ? uer_pkg::next_ptr(read_ptr_reg) : read_ptr_reg;

        trig_count_next    = trig_count_reg;
        timer_running_next = timer_running_reg;
        timeout_count_next = timeout_count_reg;
        if (s_trigger) begin
            trig_count_next    = (trig_pulse_reg == '0) ? uer_pkg::TRIG_BITS'(1)
                                                        : trig_pulse_reg;
            timer_running_next = 1'b0;
        end
        trig_out = trig_count_next != '0;
        if (trig_out) begin
            trig_count_next = trig_count_next - 1'b1;
            if (trig_count_next == '0) begin
                timer_running_next = 1'b1;
                timeout_count_next = (timeout_reg == '0) ? uer_pkg::TIMEOUT_BITS'(1)
                                                         : timeout_reg;
            end
        end

        echo_prev_next   = s_echo_level;
        rise_seen_next   = rise_seen_reg;
        width_count_next = width_count_reg;
        push             = 1'b0;
        entry            = '0;
        if (s_echo_level && !echo_prev_reg) begin
            rise_seen_next   = 1'b1;
            width_count_next = uer_pkg::COUNT_BITS'(1);
        end else if (s_echo_level && rise_seen_reg) begin
            if (width_count_reg != '1) begin
                width_count_next = width_count_reg + 1'b1;
            end
        end else if (!s_echo_level && echo_prev_reg && rise_seen_reg) begin
            push               = 1'b1;
            entry              = {1'b0, uer_pkg::sat_width(width_count_reg)};
            timer_running_next = 1'b0;
            rise_seen_next     = 1'b0;
            width_count_next   = '0;
        end

        // A falling edge has already stopped the timer, so at most one push.
        if (timer_running_next && !trig_out) begin
            if (timeout_count_next != '0) begin
                timeout_count_next = timeout_count_next - 1'b1;
            end
            if (timeout_count_next == '0) begin
                push               = 1'b1;
                entry              = {1'b1, {uer_pkg::WIDTH_BITS{1'b0}}};
                timer_running_next = 1'b0;
            end
        end

        write_ptr_inc  = uer_pkg::next_ptr(write_ptr_reg);
        push_ok        = push && (write_ptr_inc != read_ptr_next);
        write_ptr_next = push_ok ? write_ptr_inc : write_ptr_reg;

        desc_next.trig_level = trig_out;
        desc_next.data_ready = read_ptr_next != write_ptr_next;
        desc_next.pop        = pop;
        desc_next.empty      = empty;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_pulse_reg <= uer_pkg::TRIG_RESET;
            timeout_reg    <= uer_pkg::TIMEOUT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                uer_pkg::REG_TRIG_PULSE: begin
                    trig_pulse_reg <= uer_pkg::TRIG_BITS'(cfg_data);
                end
                uer_pkg::REG_TIMEOUT: begin
                    timeout_reg <= uer_pkg::TIMEOUT_BITS'(cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_prev_reg     <= 1'b0;
            rise_seen_reg     <= 1'b0;
            width_count_reg   <= '0;
            trig_count_reg    <= '0;
            timeout_count_reg <= '0;
            timer_running_reg <= 1'b0;
            read_ptr_reg      <= '0;
            write_ptr_reg     <= '0;
            desc_valid_reg    <= 1'b0;
        end else begin
            desc_valid_reg <= accept;
            if (accept) begin
                echo_prev_reg     <= echo_prev_next;
                rise_seen_reg     <= rise_seen_next;
                width_count_reg   <= width_count_next;
                trig_count_reg    <= trig_count_next;
                timeout_count_reg <= timeout_count_next;
                timer_running_reg <= timer_running_next;
                read_ptr_reg      <= read_ptr_next;
                write_ptr_reg     <= write_ptr_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            desc_reg <= desc_next;
        end
    end

    assign desc_valid    = desc_valid_reg;
    assign desc          = desc_reg;
    assign ram_req.we    = accept && push_ok;
    assign ram_req.waddr = write_ptr_reg;
    assign ram_req.wdata = entry;
    assign ram_req.re    = accept;
    assign ram_req.raddr = read_ptr_reg;

endmodule

// File: sv/uer_back.sv
module uer_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              desc_valid,
    input  uer_pkg::desc_t                    desc,
    input  logic [uer_pkg::ENTRY_BITS-1:0]    rdata,
    output logic [uer_pkg::QCNT_BITS-1:0]     back_count,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_trig_level,
    output logic                              m_data_ready,
    output logic                              m_read_ok,
    output logic                              m_read_timeout,
    output logic                              m_read_empty,
    output logic [uer_pkg::WIDTH_BITS-1:0]    m_read_width
);

    uer_pkg::result_t               q_reg [uer_pkg::QDEPTH];
    uer_pkg::result_t               res;
    uer_pkg::result_t               head;
    logic [uer_pkg::QPTR_BITS-1:0]  head_reg, head_next;
    logic [uer_pkg::QPTR_BITS-1:0]  tail_reg, tail_next;
    logic [uer_pkg::QCNT_BITS-1:0]  count_reg, count_next;
    logic                           deq;
    logic                           is_marker;

    // Merge the tick summary with the entry the buffer returned.
    always_comb begin
        is_marker        = rdata[uer_pkg::ENTRY_BITS-1];
        res.trig_level   = desc.trig_level;
        res.data_ready   = desc.data_ready;
        res.read_ok      = desc.pop && !is_marker;
        res.read_timeout = desc.pop && is_marker;
        res.read_empty   = desc.empty;
        res.read_width   = (desc.pop && !is_marker) ? rdata[uer_pkg::WIDTH_BITS-1:0] : '0;
    end

    assign deq = m_valid && m_ready;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (deq) begin
            head_next = (head_reg == uer_pkg::QPTR_BITS'(uer_pkg::QDEPTH - 1)) ? '0
                                                                               : head_reg + 1'b1;
        end
        if (desc_valid) begin
            tail_next = (tail_reg == uer_pkg::QPTR_BITS'(uer_pkg::QDEPTH - 1)) ? '0
                                                                               : tail_reg + 1'b1;
        end
        if (desc_valid && !deq) begin
            count_next = count_reg + 1'b1;
        end else if (!desc_valid && deq) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (desc_valid) begin
            q_reg[tail_reg] <= res;
        end
    end

    assign head           = q_reg[head_reg];
    assign back_count     = count_reg;
    assign m_valid        = count_reg != '0;
    assign m_trig_level   = head.trig_level;
    assign m_data_ready   = head.data_ready;
    assign m_read_ok      = head.read_ok;
    assign m_read_timeout = head.read_timeout;
    assign m_read_empty   = head.read_empty;
    assign m_read_width   = head.read_width;

endmodule

// File: test/tb_ultrasonic_echo_ranger_core.sv
module tb_ultrasonic_echo_ranger_core;
    import uer_pkg::*;

    // Cycles without any handshake on any channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Extra idle cycles after the last result.
    localparam int SETTLE_CYCLES = 10;

    typedef logic [PTR_BITS-1:0] slot_t;

    // The scoreboard keeps its own copy of the ranger state. Every accepted tick
    // produces exactly one expected report, and every result beat is checked
    // against the oldest report still due.
    class ranger_scoreboard;
        localparam logic [ENTRY_BITS-1:0] MARKER_ENTRY = ENTRY_BITS'(1) << WIDTH_BITS;
        localparam longint WIDTH_MAX = (64'd1 << WIDTH_BITS) - 64'd1;

        logic [TRIG_BITS-1:0]    pulse_len;
        logic [TIMEOUT_BITS-1:0] timeout_len;

        logic                    echo_q;
        logic                    armed;
        logic [COUNT_BITS-1:0]   high_ticks;
        logic [TRIG_BITS-1:0]    pulse_left;
        logic [TIMEOUT_BITS-1:0] timeout_left;
        logic                    timer_on;
        logic [ENTRY_BITS-1:0]   ring [FIFO_DEPTH];
        slot_t                   rd_slot;
        slot_t                   wr_slot;

        result_t reports_due[$];

        int errors;
        int ticks_logged;
        int beats_checked;
        int widths_read;
        int markers_read;
        int empty_reads;
        int dropped_pushes;
        int longest_width;

        function new();
            pulse_len     = TRIG_RESET;
            timeout_len   = TIMEOUT_RESET;
            echo_q        = 1'b0;
            armed         = 1'b0;
            high_ticks    = '0;
            pulse_left    = '0;
            timeout_left  = '0;
            timer_on      = 1'b0;
            rd_slot       = '0;
            wr_slot       = '0;
            errors        = 0;
            ticks_logged  = 0;
            beats_checked = 0;
            widths_read   = 0;
            markers_read  = 0;
            empty_reads   = 0;
            dropped_pushes = 0;
            longest_width = 0;
        endfunction

        function slot_t advance(slot_t p);
            return PTR_BITS'((int'(p) + 1) % FIFO_DEPTH);
        endfunction

        // One slot always stays free, so a push that would close the ring is lost.
        function void push_entry(logic [ENTRY_BITS-1:0] entry);
            if (advance(wr_slot) == rd_slot) begin
                dropped_pushes++;
            end else begin
                ring[wr_slot] = entry;
                wr_slot = advance(wr_slot);
            end
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] value);
            if (idx == REG_TRIG_PULSE) begin
                pulse_len = value[TRIG_BITS-1:0];
            end else if (idx == REG_TIMEOUT) begin
                timeout_len = value[TIMEOUT_BITS-1:0];
            end
        endfunction

        function int pending();
            return reports_due.size();
        endfunction

        function void log_tick(logic echo, logic trig, logic rd);
            result_t               want;
            logic [ENTRY_BITS-1:0] entry;
            logic [WIDTH_BITS-1:0] span;
            logic                  pin;

            want = '0;
            ticks_logged++;

            // The read sees the ring as it stood at the start of the tick.
            if (rd) begin
                if (rd_slot == wr_slot) begin
                    want.read_empty = 1'b1;
                end else begin
                    entry = ring[rd_slot];
                    rd_slot = advance(rd_slot);
                    if (entry[WIDTH_BITS]) begin
                        want.read_timeout = 1'b1;
                    end else begin
                        want.read_ok = 1'b1;
                        want.read_width = entry[WIDTH_BITS-1:0];
                    end
                end
            end

            // A zero pulse or timeout length behaves as one tick.
            if (trig) begin
                pulse_left = (pulse_len == '0) ? TRIG_BITS'(1) : pulse_len;
                timer_on = 1'b0;
            end
            pin = (pulse_left != '0);
            if (pulse_left != '0) begin
                pulse_left--;
                if (pulse_left == '0) begin
                    timer_on = 1'b1;
                    timeout_left = (timeout_len == '0) ? TIMEOUT_BITS'(1) : timeout_len;
                end
            end

            if (echo && !echo_q) begin
                armed = 1'b1;
                high_ticks = COUNT_BITS'(1);
            end else if (echo && armed) begin
                if (high_ticks != '1) begin
                    high_ticks++;
                end
            end else if (!echo && echo_q && armed) begin
                if (64'(high_ticks) > WIDTH_MAX) begin
                    span = '1;
                end else begin
                    span = WIDTH_BITS'(high_ticks);
                end
                push_entry({1'b0, span});
                timer_on = 1'b0;
                armed = 1'b0;
                high_ticks = '0;
            end
            echo_q = echo;

            // The timeout only runs once the trigger pin is low again.
            if (timer_on && !pin) begin
                if (timeout_left != '0) begin
                    timeout_left--;
                end
                if (timeout_left == '0) begin
                    push_entry(MARKER_ENTRY);
                    timer_on = 1'b0;
                end
            end

            want.trig_level = pin;
            want.data_ready = (rd_slot != wr_slot);
            reports_due.push_back(want);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40) begin
                $display("MISMATCH %0d: %s", errors, what);
            end
        endtask

        task compare(string field, logic [WIDTH_BITS-1:0] got, logic [WIDTH_BITS-1:0] want);
            if (got !== want) begin
                report($sformatf("beat %0d %s got %0h expected %0h",
                                 beats_checked, field, got, want));
            end
        endtask

        task check_report(result_t got);
            result_t want;
            if (reports_due.size() == 0) begin
                report($sformatf("result beat %0d arrived with no tick waiting", beats_checked));
                beats_checked++;
                return;
            end
            want = reports_due.pop_front();
            compare("trig_level", WIDTH_BITS'(got.trig_level), WIDTH_BITS'(want.trig_level));
            compare("data_ready", WIDTH_BITS'(got.data_ready), WIDTH_BITS'(want.data_ready));
            compare("read_ok", WIDTH_BITS'(got.read_ok), WIDTH_BITS'(want.read_ok));
            compare("read_timeout", WIDTH_BITS'(got.read_timeout),
                    WIDTH_BITS'(want.read_timeout));
            compare("read_empty", WIDTH_BITS'(got.read_empty), WIDTH_BITS'(want.read_empty));
            compare("read_width", got.read_width, want.read_width);
            if (want.read_ok) begin
                widths_read++;
                if (int'(want.read_width) > longest_width) begin
                    longest_width = int'(want.read_width);
                end
            end
            if (want.read_timeout) markers_read++;
            if (want.read_empty) empty_reads++;
            beats_checked++;
        endtask

        task close_out();
            if (reports_due.size() != 0) begin
                report($sformatf("%0d expected result beats never arrived", reports_due.size()));
            end
        endtask
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_echo_level;
    logic                      s_trigger;
    logic                      s_read_req;
    logic                      m_valid;
    logic                      m_ready;
    logic                      m_trig_level;
    logic                      m_data_ready;
    logic                      m_read_ok;
    logic                      m_read_timeout;
    logic                      m_read_empty;
    logic [WIDTH_BITS-1:0]     m_read_width;

    ranger_scoreboard sb;
    result_t          result_beat;
    int               quiet_cycles;
    int               settings_used;
    bit               source_calm;
    bit               sink_calm;

    ultrasonic_echo_ranger_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_echo_level   (s_echo_level),
        .s_trigger      (s_trigger),
        .s_read_req     (s_read_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_trig_level   (m_trig_level),
        .m_data_ready   (m_data_ready),
        .m_read_ok      (m_read_ok),
        .m_read_timeout (m_read_timeout),
        .m_read_empty   (m_read_empty),
        .m_read_width   (m_read_width)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // All handshakes are observed here, in one place, at the rising edge. Ticks are
    // logged before results are checked so that the order of processes never matters.
    // The same block runs the watchdog: any accepted beat on any channel resets it.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                sb.log_tick(s_echo_level, s_trigger, s_read_req);
            end
            if (m_valid && m_ready) begin
                result_beat.trig_level   = m_trig_level;
                result_beat.data_ready   = m_data_ready;
                result_beat.read_ok      = m_read_ok;
                result_beat.read_timeout = m_read_timeout;
                result_beat.read_empty   = m_read_empty;
                result_beat.read_width   = m_read_width;
                sb.check_report(result_beat);
            end
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Result side: before each beat it stalls for a random number of cycles, except
    // in calm stretches where it keeps ready high. The mode flips now and then.
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 49) == 0) begin
                sink_calm = !sink_calm;
            end
            stall = sink_calm ? 0 : $urandom_range(0, 15);
            repeat (stall) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    function automatic logic coin(input int odds);
        return ($urandom_range(0, odds - 1) == 0);
    endfunction

    // Sends one tick. Outside calm stretches valid drops for a random gap first;
    // once raised, valid and the payload hold until the beat is taken.
    task automatic send_tick(input logic echo, input logic trig, input logic rd);
        int gap;
        gap = source_calm ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_echo_level <= echo;
        s_trigger    <= trig;
        s_read_req   <= rd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stops the tick stream and waits until every expected report has come back,
    // then waits out the settle period, so that the block is idle for a register write.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Writes both registers in a random order; the block must already be idle.
    task automatic set_ranger(input int pulse, input int tmo);
        if (coin(2)) begin
            write_reg(REG_TRIG_PULSE, CFG_DATA_BITS'(pulse));
            write_reg(REG_TIMEOUT, CFG_DATA_BITS'(tmo));
        end else begin
            write_reg(REG_TIMEOUT, CFG_DATA_BITS'(tmo));
            write_reg(REG_TRIG_PULSE, CFG_DATA_BITS'(pulse));
        end
        settings_used++;
    endtask

    // One random stretch of ticks. Half of them look like a real ranging cycle:
    // a trigger, a quiet gap, an echo pulse of random width and random reads.
    // The rest are timeouts, bursts of reads and plain noise.
    task automatic run_sequence(input int pulse, input int tmo, output int sent);
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        sent = 0;
        if (coin(6)) begin
            source_calm = !source_calm;
        end
        if (pick < 50) begin
            send_tick(1'b0, 1'b1, coin(4));
            n = $urandom_range(0, 4);
            repeat (n) send_tick(1'b0, 1'b0, coin(4));
            sent += n + 1;
            n = coin(10) ? $urandom_range(13, 60) : $urandom_range(1, 12);
            repeat (n) send_tick(1'b1, 1'b0, coin(4));
            sent += n;
            n = $urandom_range(1, 3);
            repeat (n) send_tick(1'b0, 1'b0, coin(4));
            sent += n;
        end else if (pick < 65) begin
            // Trigger and stay silent long enough for a short timeout to expire.
            send_tick(1'b0, 1'b1, 1'b0);
            n = (pulse + tmo + 1 > 40) ? 40 : pulse + tmo + 1;
            repeat (n) send_tick(1'b0, 1'b0, coin(6));
            sent += n + 1;
        end else if (pick < 80) begin
            n = $urandom_range(1, 6);
            repeat (n) send_tick(1'b0, 1'b0, 1'b1);
            sent += n;
        end else begin
            n = $urandom_range(1, 8);
            repeat (n) send_tick(coin(2), coin(2), coin(2));
            sent += n;
        end
    endtask

    // Overfills the ring with short echo pulses so that pushes are dropped, then
    // lets some reads free a slot on the very tick of a falling edge, and finally
    // reads the ring dry and once more past empty.
    task automatic fill_and_drain();
        int k;
        for (k = 0; k < FIFO_DEPTH + 8; k++) begin
            repeat (coin(3) ? 2 : 1) send_tick(1'b1, coin(8), 1'b0);
            send_tick(1'b0, coin(8), (k >= FIFO_DEPTH) ? coin(2) : 1'b0);
        end
        for (k = 0; k < FIFO_DEPTH + 2; k++) begin
            send_tick(1'b0, 1'b0, 1'b1);
        end
    endtask

    initial begin : stimulus
        int pulse_set [6];
        int tmo_set [6];
        int budget;
        int sent;
        int done;
        int p;

        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_echo_level = 1'b0;
        s_trigger    = 1'b0;
        s_read_req   = 1'b0;
        quiet_cycles = 0;
        settings_used = 0;
        source_calm  = 1'b0;
        sink_calm    = 1'b0;
        sb = new();

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. Zero in both registers has to behave as a one-tick pulse
        // and a one-tick timeout.
        set_ranger(0, 0);
        send_tick(1'b0, 1'b0, 1'b1);    // read of an empty ring
        send_tick(1'b0, 1'b1, 1'b0);    // trigger: pin high for a single tick
        send_tick(1'b0, 1'b0, 1'b0);    // timeout runs out, marker queued
        send_tick(1'b0, 1'b0, 1'b1);    // read returns the marker
        send_tick(1'b1, 1'b1, 1'b0);    // trigger together with a rising echo
        // The falling edge lands on the tick where the timeout expires; the echo
        // wins and no marker may be queued.
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);    // width of one tick
        send_tick(1'b0, 1'b0, 1'b1);    // empty again
        send_tick(1'b1, 1'b1, 1'b1);    // every field high at once
        send_tick(1'b1, 1'b0, 1'b0);    // echo still high while the timeout fires
        send_tick(1'b0, 1'b0, 1'b0);    // falling edge queues a width of two
        send_tick(1'b0, 1'b0, 1'b1);    // marker comes out first
        send_tick(1'b0, 1'b0, 1'b1);    // then the width
        settle();

        // A trigger in the middle of a pulse restarts it, and a read of an empty
        // ring on the same tick as a push still reports empty.
        set_ranger(3, 5);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        repeat (4) send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);
        settle();

        // Random part, one phase per register setting: the smallest values, two
        // short ones, the reset values, the largest values and a random short pair.
        pulse_set = '{1, 2, 5, int'(TRIG_RESET), 65535, $urandom_range(1, 8)};
        tmo_set   = '{1, 30, 200, int'(TIMEOUT_RESET), 16777215, $urandom_range(1, 100)};
        for (p = 0; p < 6; p++) begin
            set_ranger(pulse_set[p], tmo_set[p]);
            budget = (pulse_set[p] == 65535) ? 10 : 12;
            done = 0;
            while (done < budget) begin
                run_sequence(pulse_set[p], tmo_set[p], sent);
                done += sent;
            end
            settle();
        end

        set_ranger(1, 6);
        fill_and_drain();
        settle();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        sb.close_out();
        $display("Covered %0d ticks over %0d register settings; reads gave %0d widths (up to %0d),",
                 sb.ticks_logged, settings_used, sb.widths_read, sb.longest_width);
        $display("%0d timeout markers and %0d empty reads; %0d pushes were lost to a full ring.",
                 sb.markers_read, sb.empty_reads, sb.dropped_pushes);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/uer_pkg.sv
sv/uer_ram.sv
sv/uer_front.sv
sv/uer_back.sv
sv/ultrasonic_echo_ranger_core.sv
test/tb_ultrasonic_echo_ranger_core.sv
